FILE: hdl/sine_zero_crossing_phase_macros.svh
// Assertion macros shared by the zero-crossing phase estimator modules.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
// Bodies are empty when SYNTHESIS is defined.
`ifndef SINE_ZERO_CROSSING_PHASE_MACROS_SVH
`define SINE_ZERO_CROSSING_PHASE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SZCP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("szcp: implication check failed");

// Next-cycle implication
`define SZCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("szcp: next-cycle check failed");

`else

`define SZCP_ASSERT_IMPLIES(label, ante, cons)
`define SZCP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/szcp_pkg.sv
// Shared widths and divider request/response types for the zero-crossing phase estimator.
// No dependencies.
package szcp_pkg;

    localparam int TIME_W    = 20;
    localparam int VALUE_W   = 16;
    localparam int MEAN_W    = 21;
    localparam int COUNT_W   = 11;
    localparam int SUM_W     = 32;

    // Shared restoring divider: dividend shift register, remainder, iteration count
    localparam int DIV_QW    = 36;
    localparam int DIV_RW    = 20;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_RW-1:0]    rem_init;
        logic [DIV_QW-1:0]    quo_init;
        logic [DIV_RW-1:0]    divisor;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_QW-1:0] quo;
        logic [DIV_RW-1:0] rem;
    } div_rsp_t;

endpackage

FILE: hdl/szcp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on szcp_pkg and sine_zero_crossing_phase_macros.svh.
`include "sine_zero_crossing_phase_macros.svh"

module szcp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  szcp_pkg::div_req_t req,
    output szcp_pkg::div_rsp_t rsp
);
    import szcp_pkg::*;

    logic [DIV_RW-1:0]    rem_reg, rem_next;
    logic [DIV_QW-1:0]    quo_reg, quo_next;
    logic [DIV_RW-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_RW:0]      shifted;
    logic [DIV_RW:0]      diff;
    logic                 fits;

    // One trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_QW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Load on start, then shift a quotient bit in each cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.rem_init;
            quo_next  = req.quo_init;
            dvs_next  = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_RW-1:0] : shifted[DIV_RW-1:0];
            quo_next = {quo_reg[DIV_QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    `SZCP_ASSERT_IMPLIES(a_busy_has_count, busy_reg, cnt_reg != '0)
    `SZCP_ASSERT_NEXT(a_start_loads, req.start, busy_reg)
    `SZCP_ASSERT_IMPLIES(a_done_after_busy, done_reg, $past(busy_reg) && !busy_reg)

endmodule

FILE: hdl/sine_zero_crossing_phase.sv
// Zero-crossing phase estimator: top level with sequencer and record state.
// Depends on szcp_pkg, szcp_div and sine_zero_crossing_phase_macros.svh.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  in       | in_valid / in_stall        | sample_time, sample_value, last
//  out      | out_valid / out_stall      | mean_crossing, crossing_count, no_estimate
//  cfg      | cfg_valid / cfg_ready      | cfg_data (period)
//
// A sample without a crossing leaves the block idle unless it closes the record. A
// crossing sample holds in_stall through the interpolation divide and the crossing, fold,
// near and accumulate states; the first fold and the later fold may each run the divider.
// The closing sample adds the mean divide, skipped when the record is flagged, plus any wait on out_stall.
// Each divide runs on the shared restoring divider: one quotient bit per cycle
// (21 bits for interpolation, 20 for each fold, 33 for the mean).
// Reset restores period to 1280 and clears the record; no clearing pass is needed.
`include "sine_zero_crossing_phase_macros.svh"

module sine_zero_crossing_phase #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic        [szcp_pkg::TIME_W-1:0]  sample_time,
    input  logic signed [szcp_pkg::VALUE_W-1:0] sample_value,
    input  logic                                last,
    // result requests
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [szcp_pkg::MEAN_W-1:0]  mean_crossing,
    output logic        [szcp_pkg::COUNT_W-1:0] crossing_count,
    output logic                                no_estimate,
    // period register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [szcp_pkg::TIME_W-1:0]  cfg_data
);
    import szcp_pkg::*;

    localparam int IDX_W     = $clog2(MAX_SAMPLES + 1);
    localparam int DIFF_W    = TIME_W + 2;
    localparam int FOLD_W    = TIME_W + 3;
    localparam int MEAN_DW   = SUM_W + 1;

    localparam logic [TIME_W-1:0]  PERIOD_RESET = TIME_W'(1280);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam int                 MIN_SAMPLES  = 3;
    localparam int                 FIRST_PAIR   = 2;

    localparam logic [MEAN_W-1:0]  MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]  MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    localparam logic [DIV_CNT_W-1:0] ITER_INTERP = DIV_CNT_W'(TIME_W + 1);
    localparam logic [DIV_CNT_W-1:0] ITER_FOLD   = DIV_CNT_W'(TIME_W);
    localparam logic [DIV_CNT_W-1:0] ITER_MEAN   = DIV_CNT_W'(MEAN_DW);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_FIRST = 4'd4;
    localparam logic [3:0] S_FOLD  = 4'd5;
    localparam logic [3:0] S_NEAR  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_MEAN  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    // Divider jobs
    localparam logic [1:0] OP_INTERP = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_LATER  = 2'd2;
    localparam logic [1:0] OP_MEAN   = 2'd3;

    // Control and record state
    logic [3:0]                state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    logic                      last_reg, last_next;
    logic                      empty_reg, empty_next;
    logic                      out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]         period_reg, period_next;
    logic [TIME_W-1:0]         prev_time_reg, prev_time_next;
    logic signed [VALUE_W-1:0] prev_value_reg, prev_value_next;
    logic [IDX_W-1:0]          sample_index_reg, sample_index_next;
    logic [TIME_W-1:0]         first_reg, first_next;
    logic                      have_first_reg, have_first_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0]        count_reg, count_next;

    // Per-crossing working registers
    logic [TIME_W-1:0]         x1_reg, x1_next;
    logic                      cross_neg_reg, cross_neg_next;
    logic [TIME_W-1:0]         dxmag_reg, dxmag_next;
    logic [VALUE_W-1:0]        negv_reg, negv_next;
    logic [VALUE_W-1:0]        den_reg, den_next;
    logic [TIME_W-1:0]         tc_reg, tc_next;
    logic signed [DIFF_W-1:0]  d_reg, d_next;

    // Result register
    logic signed [MEAN_W-1:0]  mean_reg, mean_next;
    logic [COUNT_W-1:0]        count_out_reg, count_out_next;
    logic                      flag_reg, flag_next;

    // Combinational helpers
    logic [TIME_W-1:0]         p_eff;
    logic                      accept;
    logic                      in_range;
    logic                      is_cross;
    logic [TIME_W:0]           dx_u;
    logic [TIME_W:0]           dx_abs;
    logic [VALUE_W:0]          den_w;
    logic [DIV_QW-1:0]         product;
    logic signed [DIFF_W-1:0]  d_full;
    logic signed [DIFF_W-1:0]  p_s;
    logic signed [DIFF_W-1:0]  dm;
    logic [DIFF_W-1:0]         abs_dm;
    logic [DIFF_W-1:0]         abs_d;
    logic signed [FOLD_W-1:0]  folded;
    logic signed [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]          sum_abs;
    logic [MEAN_DW-1:0]        mean_dividend;
    logic [MEAN_DW-1:0]        mag;
    logic                      out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    szcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A zero period acts as one
    assign p_eff = (period_reg == '0) ? TIME_W'(1) : period_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // Crossing detection and interpolation operands
    always_comb
    begin
        in_range = (sample_index_reg < IDX_W'(MAX_SAMPLES));
        is_cross = in_range && (sample_index_reg >= IDX_W'(FIRST_PAIR))
                   && (prev_value_reg < 0) && (sample_value > 0);
        dx_u     = {1'b0, sample_time} - {1'b0, prev_time_reg};
        dx_abs   = dx_u[TIME_W] ? (~dx_u + 1'b1) : dx_u;
        den_w    = {sample_value[VALUE_W-1], sample_value}
                   - {prev_value_reg[VALUE_W-1], prev_value_reg};
        product  = negv_reg * dxmag_reg;
    end

    // Fold, accumulate and mean arithmetic
    always_comb
    begin
        p_s     = $signed({2'b00, p_eff});
        d_full  = $signed({2'b00, tc_reg} - {2'b00, first_reg});
        dm      = d_reg - p_s;
        abs_dm  = dm[DIFF_W-1] ? DIFF_W'(-dm) : DIFF_W'(dm);
        abs_d   = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
        folded  = $signed({3'b000, first_reg}) + $signed({d_reg[DIFF_W-1], d_reg});
        sum_ext = $signed({sum_reg[SUM_W-1], sum_reg})
                  + $signed({{(SUM_W+1-FOLD_W){folded[FOLD_W-1]}}, folded});
        sum_abs = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        mean_dividend = {1'b0, sum_abs} + MEAN_DW'(count_reg >> 1);
        mag     = div_rsp.quo[MEAN_DW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        last_next         = last_reg;
        empty_next        = empty_reg;
        out_valid_next    = out_valid_reg;
        period_next       = period_reg;
        prev_time_next    = prev_time_reg;
        prev_value_next   = prev_value_reg;
        sample_index_next = sample_index_reg;
        first_next        = first_reg;
        have_first_next   = have_first_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        x1_next           = x1_reg;
        cross_neg_next    = cross_neg_reg;
        dxmag_next        = dxmag_reg;
        negv_next         = negv_reg;
        den_next          = den_reg;
        tc_next           = tc_reg;
        d_next            = d_reg;
        mean_next         = mean_reg;
        count_out_next    = count_out_reg;
        flag_next         = flag_reg;
        div_req           = '0;

        // result taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // period register write
        if (cfg_valid && cfg_ready)
        begin
            period_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = last;
                    if (in_range)
                    begin
                        prev_time_next    = sample_time;
                        prev_value_next   = sample_value;
                        sample_index_next = sample_index_reg + 1'b1;
                    end
                    if (is_cross)
                    begin
                        x1_next        = prev_time_reg;
                        cross_neg_next = dx_u[TIME_W];
                        dxmag_next     = dx_abs[TIME_W-1:0];
                        negv_next      = ~prev_value_reg + 1'b1;
                        den_next       = den_w[VALUE_W-1:0];
                        state_next     = S_MUL;
                    end
                    else if (last)
                    begin
                        state_next = S_MEAN;
                    end
                end
            end
            // product goes straight into the divider registers
            S_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.rem_init = DIV_RW'(product[DIV_QW-1:TIME_W+1]);
                div_req.quo_init = {product[TIME_W:0], {(DIV_QW-TIME_W-1){1'b0}}};
                div_req.divisor  = DIV_RW'(den_reg);
                div_req.iters    = ITER_INTERP;
                op_next          = OP_INTERP;
                state_next       = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (op_reg)
                        OP_INTERP:
                        begin
                            state_next = S_CROSS;
                        end
                        OP_FIRST:
                        begin
                            first_next      = (div_rsp.rem == '0) ? p_eff
                                                                  : div_rsp.rem[TIME_W-1:0];
                            have_first_next = 1'b1;
                            state_next      = S_FOLD;
                        end
                        OP_LATER:
                        begin
                            d_next     = $signed({2'b00, div_rsp.rem[TIME_W-1:0]})
                                         + DIFF_W'(1);
                            state_next = S_NEAR;
                        end
                        OP_MEAN:
                        begin
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // crossing time, truncated toward zero
            S_CROSS:
            begin
                tc_next    = cross_neg_reg ? (x1_reg - div_rsp.quo[TIME_W-1:0])
                                           : (x1_reg + div_rsp.quo[TIME_W-1:0]);
                state_next = S_FIRST;
            end
            // first crossing folded into one period
            S_FIRST:
            begin
                if (have_first_reg)
                begin
                    state_next = S_FOLD;
                end
                else if (tc_reg > p_eff)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.quo_init = {tc_reg, {(DIV_QW-TIME_W){1'b0}}};
                    div_req.divisor  = p_eff;
                    div_req.iters    = ITER_FOLD;
                    op_next          = OP_FIRST;
                    state_next       = S_DIV;
                end
                else
                begin
                    first_next      = tc_reg;
                    have_first_next = 1'b1;
                    state_next      = S_FOLD;
                end
            end
            // distance to first crossing, reduced into (0, period] when past it
            S_FOLD:
            begin
                if (d_full > p_s)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.quo_init = {d_full[TIME_W-1:0] - 1'b1,
                                        {(DIV_QW-TIME_W){1'b0}}};
                    div_req.divisor  = p_eff;
                    div_req.iters    = ITER_FOLD;
                    op_next          = OP_LATER;
                    state_next       = S_DIV;
                end
                else
                begin
                    d_next     = d_full;
                    state_next = S_NEAR;
                end
            end
            // one more period back if that lands nearer
            S_NEAR:
            begin
                if (abs_dm < abs_d)
                begin
                    d_next = dm;
                end
                state_next = S_ACC;
            end
            // saturating sum and count
            S_ACC:
            begin
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                begin
                    sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_ext[SUM_W-1:0];
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? S_MEAN : S_IDLE;
            end
            // end of record: mean divide or flagged zero
            S_MEAN:
            begin
                if ((sample_index_reg < IDX_W'(MIN_SAMPLES)) || (count_reg == '0))
                begin
                    empty_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    empty_next       = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.quo_init = {mean_dividend, {(DIV_QW-MEAN_DW){1'b0}}};
                    div_req.divisor  = DIV_RW'(count_reg);
                    div_req.iters    = ITER_MEAN;
                    op_next          = OP_MEAN;
                    state_next       = S_DIV;
                end
            end
            // load result register, clear record
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (empty_reg)
                    begin
                        mean_next = '0;
                    end
                    else if (!sum_reg[SUM_W-1])
                    begin
                        mean_next = (mag > MEAN_DW'(MEAN_MAX)) ? MEAN_MAX
                                                               : mag[MEAN_W-1:0];
                    end
                    else
                    begin
                        mean_next = (mag > MEAN_DW'(MEAN_MIN)) ? MEAN_MIN
                                                               : (~mag[MEAN_W-1:0] + 1'b1);
                    end
                    count_out_next    = count_reg;
                    flag_next         = empty_reg;
                    out_valid_next    = 1'b1;
                    prev_time_next    = '0;
                    prev_value_next   = '0;
                    sample_index_next = '0;
                    first_next        = '0;
                    have_first_next   = 1'b0;
                    sum_next          = '0;
                    count_next        = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_INTERP;
            last_reg         <= 1'b0;
            empty_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            period_reg       <= PERIOD_RESET;
            prev_time_reg    <= '0;
            prev_value_reg   <= '0;
            sample_index_reg <= '0;
            first_reg        <= '0;
            have_first_reg   <= 1'b0;
            sum_reg          <= '0;
            count_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            last_reg         <= last_next;
            empty_reg        <= empty_next;
            out_valid_reg    <= out_valid_next;
            period_reg       <= period_next;
            prev_time_reg    <= prev_time_next;
            prev_value_reg   <= prev_value_next;
            sample_index_reg <= sample_index_next;
            first_reg        <= first_next;
            have_first_reg   <= have_first_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        x1_reg        <= x1_next;
        cross_neg_reg <= cross_neg_next;
        dxmag_reg     <= dxmag_next;
        negv_reg      <= negv_next;
        den_reg       <= den_next;
        tc_reg        <= tc_next;
        d_reg         <= d_next;
        mean_reg      <= mean_next;
        count_out_reg <= count_out_next;
        flag_reg      <= flag_next;
    end

    assign out_valid      = out_valid_reg;
    assign mean_crossing  = mean_reg;
    assign crossing_count = count_out_reg;
    assign no_estimate    = flag_reg;

    `SZCP_ASSERT_IMPLIES(a_div_free, div_req.start, !div_rsp.busy)
    `SZCP_ASSERT_IMPLIES(a_first_before_count, !have_first_reg, count_reg == '0)
    `SZCP_ASSERT_IMPLIES(a_count_needs_samples, count_reg != '0,
                         sample_index_reg >= IDX_W'(MIN_SAMPLES))
    `SZCP_ASSERT_IMPLIES(a_interp_fits,
                         (state_reg == S_DIV) && (op_reg == OP_INTERP) && div_rsp.done,
                         div_rsp.quo[DIV_QW-1:TIME_W] == '0)

endmodule

FILE: dv/sine_zero_crossing_phase_tb.sv
// Self-checking testbench for the sine zero-crossing phase estimator.
// Depends on szcp_pkg and the sine_zero_crossing_phase RTL. A directed table
// comes first, then randomized records under several period settings.
module sine_zero_crossing_phase_tb;

    import szcp_pkg::*;

    localparam int RECORD_CAP = 1024;
    localparam int HOLD_CYCLES = 800;
    localparam int SETTLE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 60;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;
    localparam longint MEAN_HI = 64'sd1048575;
    localparam longint MEAN_LO = -64'sd1048576;
    localparam int COUNT_SAT = 2047;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [COUNT_W-1:0]       count;
        logic                     flag;
    } phase_est_t;

    typedef struct {
        logic [TIME_W-1:0]         t;
        logic signed [VALUE_W-1:0] v;
        logic                      lst;
        bit                        typed;
        phase_est_t                want;
    } directed_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [TIME_W-1:0]          sample_time = '0;
    logic signed [VALUE_W-1:0]  sample_value = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [MEAN_W-1:0]   mean_crossing;
    logic [COUNT_W-1:0]         crossing_count;
    logic                       no_estimate;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [TIME_W-1:0]          cfg_data = '0;

    // predictor state
    logic [TIME_W-1:0]          period_setting = 20'd1280;
    logic [TIME_W-1:0]          prior_time = '0;
    logic signed [VALUE_W-1:0]  prior_value = '0;
    int unsigned                samples_in_record = 0;
    longint                     first_fold = 0;
    bit                         first_seen = 0;
    longint                     crossing_total = 0;
    int unsigned                crossing_tally = 0;

    phase_est_t                 pending_estimates[$];
    directed_row_t              directed_rows[$];

    int  errors = 0;
    int  items_sent = 0;
    int  records_sent = 0;
    int  estimates_checked = 0;
    int  flagged_seen = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_asked = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    sine_zero_crossing_phase #(
        .MAX_SAMPLES(RECORD_CAP)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_time    (sample_time),
        .sample_value   (sample_value),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mean_crossing  (mean_crossing),
        .crossing_count (crossing_count),
        .no_estimate    (no_estimate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint mag64(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Fold one crossing toward the first one and add it to the running sum
    task automatic fold_crossing(input longint t, input longint p);
        longint d;
        longint r;
        if (!first_seen)
        begin
            if (t > p)
            begin
                r = t % p;
                first_fold = (r == 0) ? p : r;
            end
            else
                first_fold = t;
            first_seen = 1'b1;
        end
        d = t - first_fold;
        if (d > p)
            d -= p * ((d - 1) / p);
        if (mag64(d - p) < mag64(d))
            d -= p;
        crossing_total += first_fold + d;
        if (crossing_total > SUM_HI)
            crossing_total = SUM_HI;
        if (crossing_total < SUM_LO)
            crossing_total = SUM_LO;
        if (crossing_tally < COUNT_SAT)
            crossing_tally++;
    endtask

    // Take one accepted sample; on the closing sample produce the mean estimate
    task automatic advance_phase_estimate(input logic [TIME_W-1:0] t,
                                          input logic signed [VALUE_W-1:0] v,
                                          input logic lst,
                                          output bit produced,
                                          output phase_est_t est);
        longint p;
        longint dx;
        longint num;
        longint den;
        longint c;
        longint mag;
        longint mean;
        p = (period_setting == 0) ? 64'sd1 : longint'(period_setting);
        produced = 1'b0;
        est = '0;
        if (samples_in_record < RECORD_CAP)
        begin
            // rising crossing, skipping the pair of sample 0 and sample 1
            if (samples_in_record >= 2 && prior_value < 0 && v > 0)
            begin
                dx = longint'(t) - longint'(prior_time);
                num = -longint'(prior_value) * dx;
                den = longint'(v) - longint'(prior_value);
                fold_crossing(longint'(prior_time) + num / den, p);
            end
            prior_time = t;
            prior_value = v;
            samples_in_record++;
        end
        if (lst)
        begin
            produced = 1'b1;
            if (samples_in_record < 3 || crossing_tally == 0)
                est.flag = 1'b1;
            else
            begin
                c = crossing_tally;
                mag = (mag64(crossing_total) + c / 2) / c;
                mean = (crossing_total < 0) ? -mag : mag;
                if (mean > MEAN_HI)
                    mean = MEAN_HI;
                if (mean < MEAN_LO)
                    mean = MEAN_LO;
                est.mean = mean[MEAN_W-1:0];
            end
            est.count = crossing_tally[COUNT_W-1:0];
            prior_time = '0;
            prior_value = '0;
            samples_in_record = 0;
            first_fold = 0;
            first_seen = 1'b0;
            crossing_total = 0;
            crossing_tally = 0;
        end
    endtask

    // Offer one sample request and hold it until accepted; call at a rising edge
    task automatic offer_sample(input logic [TIME_W-1:0] t,
                                input logic signed [VALUE_W-1:0] v,
                                input logic lst,
                                input bit typed,
                                input phase_est_t want);
        bit produced;
        phase_est_t est;
        in_valid <= 1'b1;
        sample_time <= t;
        sample_value <= v;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_phase_estimate(t, v, lst, produced, est);
        if (produced)
            pending_estimates.insert(pending_estimates.size(), typed ? want : est);
        items_sent++;
        if (lst)
            records_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Drain, let the block settle, then write the period register
    task automatic write_period(input logic [TIME_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        period_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [TIME_W-1:0] t, input logic signed [VALUE_W-1:0] v,
                           input logic lst, input bit typed,
                           input logic signed [MEAN_W-1:0] mean,
                           input logic [COUNT_W-1:0] count, input logic flag);
        directed_row_t row;
        row.t = t;
        row.v = v;
        row.lst = lst;
        row.typed = typed;
        row.want.mean = mean;
        row.want.count = count;
        row.want.flag = flag;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // One random record: mostly sine-like alternation, some noise and short ones
    task automatic run_record(input int forced_len);
        int kind;
        int len;
        int half;
        int offset;
        int step;
        int amp;
        int mag;
        logic [TIME_W-1:0] t;
        logic signed [VALUE_W-1:0] v;
        kind = (forced_len > 0) ? 0 : $urandom_range(0, 99);
        if (forced_len > 0)
            len = forced_len;
        else if (kind < 75)
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(3, 24);
        else if (kind < 90)
            len = $urandom_range(1, 8);
        else
            len = $urandom_range(1, 2);
        t = TIME_W'($urandom);
        half = $urandom_range(1, 6);
        offset = $urandom_range(0, 11);
        step = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 65535);
        amp = (1 << $urandom_range(0, 15)) - 1;
        if (amp == 0)
            amp = 1;
        for (int i = 0; i < len; i++)
        begin
            if (kind >= 75 && kind < 90)
            begin
                t = TIME_W'($urandom);
                v = VALUE_W'($urandom);
            end
            else
            begin
                mag = $urandom_range(1, amp);
                v = VALUE_W'((((i + offset) / half) % 2 == 1) ? -mag : mag);
                if ($urandom_range(0, 19) == 0)
                    v = '0;
                else if ($urandom_range(0, 49) == 0)
                    v = (v < 0) ? -16'sd32768 : 16'sd32767;
                t = TIME_W'(t + step + $urandom_range(0, step / 4));
            end
            offer_sample(t, v, (i == len - 1), 1'b0, '0);
        end
    endtask

    // Receiver: random stall, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Compare each accepted result with the oldest pending estimate
    always @(posedge clk)
    begin : check_results
        phase_est_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_estimates.size() == 0)
            begin
                $error("result with no estimate pending: mean %0d count %0d flag %0b",
                       mean_crossing, crossing_count, no_estimate);
                errors++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                estimates_checked++;
                if (no_estimate)
                    flagged_seen++;
                if (mean_crossing !== want.mean)
                begin
                    $error("mean_crossing: expected %0d, got %0d", want.mean, mean_crossing);
                    errors++;
                end
                if (crossing_count !== want.count)
                begin
                    $error("crossing_count: expected %0d, got %0d", want.count, crossing_count);
                    errors++;
                end
                if (no_estimate !== want.flag)
                begin
                    $error("no_estimate: expected %0b, got %0b", want.flag, no_estimate);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no request accepted anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("sine_zero_crossing_phase verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TIME_W-1:0] phase_period[6];
        int phase_items;

        // single sample, pair 0/1 crossing skipped, extremes with zero samples
        add_row(20'd0, 16'sd0, 1'b1, 1'b1, 21'sd0, 11'd0, 1'b1);
        add_row(20'd0, -16'sd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd100, 16'sd5, 1'b1, 1'b1, 21'sd0, 11'd0, 1'b1);
        add_row(20'd1048575, 16'sd32767, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd0, -16'sd32768, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd1048575, 16'sd0, 1'b1, 1'b1, 21'sd0, 11'd0, 1'b1);
        // one plain crossing
        add_row(20'd0, 16'sd5, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd4096, -16'sd100, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd8192, 16'sd100, 1'b1, 1'b0, '0, '0, 1'b0);
        // full-scale swing, then a crossing with time running backward
        add_row(20'd0, 16'sd0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd0, -16'sd32768, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd1048575, 16'sd32767, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd1048575, -16'sd1, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd0, 16'sd1, 1'b1, 1'b0, '0, '0, 1'b0);
        // several crossings spread over several periods
        add_row(20'd0, -16'sd1, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd600, -16'sd1000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd1200, 16'sd1000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd1800, -16'sd1000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd2400, 16'sd1000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd3000, -16'sd1000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd3600, 16'sd1000, 1'b1, 1'b0, '0, '0, 1'b0);
        // passing through an exact zero is not a crossing
        add_row(20'd0, 16'sd1, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd10, -16'sd3, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd20, 16'sd0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(20'd30, 16'sd3, 1'b1, 1'b1, 21'sd0, 11'd0, 1'b1);

        phase_period[0] = 20'd1;
        phase_period[1] = 20'd1048575;
        phase_period[2] = 20'd0;
        phase_period[3] = 20'd3000;
        phase_period[4] = TIME_W'($urandom_range(1, 20000));
        phase_period[5] = TIME_W'($urandom_range(1, 1048575));

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset period
        tx_idle_pct = 17;
        rx_idle_pct <= 77;
        foreach (directed_rows[i])
            offer_sample(directed_rows[i].t, directed_rows[i].v, directed_rows[i].lst,
                         directed_rows[i].typed, directed_rows[i].want);

        // random records, one period setting per phase
        for (int ph = 0; ph < 6; ph++)
        begin
            write_period(phase_period[ph]);
            tx_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 77 : 0;
            rx_idle_pct <= (ph < 2) ? 77 : (ph < 4) ? 17 : 0;
            phase_items = items_sent;
            if (ph == 5)
                run_record(RECORD_CAP + 6);
            while (items_sent - phase_items < PHASE_ITEMS)
            begin
                // receiver holds off while samples keep coming
                if (ph == 4 && items_sent - phase_items >= 10 && hold_asked == 0)
                    hold_asked <= hold_asked + 1;
                run_record(0);
            end
        end

        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("run: %0d samples in %0d records over 7 period settings (0, 1, max included)",
                 items_sent, records_sent);
        $display("run: %0d estimates compared, %0d of them flagged without estimate",
                 estimates_checked, flagged_seen);
        if (errors == 0)
            $display("sine_zero_crossing_phase verification clean");
        else
            $display("sine_zero_crossing_phase verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/szcp_pkg.sv
hdl/szcp_div.sv
hdl/sine_zero_crossing_phase.sv
dv/sine_zero_crossing_phase_tb.sv
